// ===== design/dqcl_pkg.sv =====
`default_nettype none
package dqcl_pkg;

    localparam int CURRENT_BITS_DEF       = 20;
    localparam int STEP_FRACTION_BITS_DEF = 16;

    // register port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam int MAG_RESET  = 10240;
    localparam int MIN_RESET  = -10240;
    localparam int MAX_RESET  = 10240;

    typedef enum logic [2:0] {
        REG_MAG   = 3'd0,
        REG_D_MIN = 3'd1,
        REG_D_MAX = 3'd2,
        REG_Q_MIN = 3'd3,
        REG_Q_MAX = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        FUNC_PREPARE = 2'd0,
        FUNC_STEP    = 2'd1,
        FUNC_RESET   = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

endpackage
`default_nettype wire

// ===== design/dqcl_mul.sv =====
`default_nettype none
module dqcl_mul #(
    parameter int W = 22
) (
    input  wire logic                    i_clk,
    input  wire logic signed [W-1:0]     i_a,
    input  wire logic signed [W-1:0]     i_b,
    output logic signed      [2*W-1:0]   o_p
);

    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== design/dqcl_regs.sv =====
`default_nettype none
module dqcl_regs #(
    parameter int CURRENT_BITS = dqcl_pkg::CURRENT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dqcl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dqcl_pkg::DATA_W-1:0]   pwdata,
    output logic      [dqcl_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [CURRENT_BITS-2:0]       o_mag,
    output logic      [CURRENT_BITS-1:0]       o_d_min,
    output logic      [CURRENT_BITS-2:0]       o_d_max,
    output logic      [CURRENT_BITS-1:0]       o_q_min,
    output logic      [CURRENT_BITS-2:0]       o_q_max
);

    localparam int CB = CURRENT_BITS;

    logic [CB-2:0] r_mag;
    logic [CB-1:0] r_d_min;
    logic [CB-2:0] r_d_max;
    logic [CB-1:0] r_q_min;
    logic [CB-2:0] r_q_max;
    dqcl_pkg::t_reg_idx idx;
    logic wr;

    assign idx    = dqcl_pkg::t_reg_idx'(paddr[dqcl_pkg::ADDR_W-1:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= (CB-1)'(dqcl_pkg::MAG_RESET);
            r_d_min <= CB'(dqcl_pkg::MIN_RESET);
            r_d_max <= (CB-1)'(dqcl_pkg::MAX_RESET);
            r_q_min <= CB'(dqcl_pkg::MIN_RESET);
            r_q_max <= (CB-1)'(dqcl_pkg::MAX_RESET);
        end else if (wr) begin
            unique case (idx)
                dqcl_pkg::REG_MAG:   r_mag   <= pwdata[CB-2:0];
                dqcl_pkg::REG_D_MIN: r_d_min <= pwdata[CB-1:0];
                dqcl_pkg::REG_D_MAX: r_d_max <= pwdata[CB-2:0];
                dqcl_pkg::REG_Q_MIN: r_q_min <= pwdata[CB-1:0];
                dqcl_pkg::REG_Q_MAX: r_q_max <= pwdata[CB-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            dqcl_pkg::REG_MAG:   prdata = dqcl_pkg::DATA_W'(r_mag);
            dqcl_pkg::REG_D_MIN: prdata = dqcl_pkg::DATA_W'(r_d_min);
            dqcl_pkg::REG_D_MAX: prdata = dqcl_pkg::DATA_W'(r_d_max);
            dqcl_pkg::REG_Q_MIN: prdata = dqcl_pkg::DATA_W'(r_q_min);
            dqcl_pkg::REG_Q_MAX: prdata = dqcl_pkg::DATA_W'(r_q_max);
            default:             prdata = '0;
        endcase
    end

    assign o_mag   = r_mag;
    assign o_d_min = r_d_min;
    assign o_d_max = r_d_max;
    assign o_q_min = r_q_min;
    assign o_q_max = r_q_max;

endmodule
`default_nettype wire

// ===== design/dq_current_reference_limiter_unit.sv =====
// dq current reference limiter
// input channel: i_in_valid / o_in_stall carries one word (func, value, target,
// target flag); output channel: o_out_valid / i_out_stall carries the limited
// d/q reference with its saturated and rate_limited flags. the user must write
// the registers over the apb port only while the block is idle; the block
// itself does not enforce this. one word is worked on at a time through a
// single shared multiplier and a bit-serial search for the scale, one result
// bit per pass through IT1 and IT2. the unused func code skips to the done
// state; other words are checked against the circle, and a step whose value
// lies outside it also checks the stored reference. the search runs only when
// the vector must be pulled onto the circle. o_in_stall is high from accept
// until the result is moved into the output register, so the next word is
// taken in the cycle after that at the earliest; the output register then
// waits for the receiver while the next word is worked on. a stalled receiver
// holds the result in place and, after the next word finishes, holds that word
// in the done state. reset clears the stored reference to zero, loads the
// register defaults and empties the output register.
`default_nettype none
module dq_current_reference_limiter_unit #(
    parameter int CURRENT_BITS       = dqcl_pkg::CURRENT_BITS_DEF,
    parameter int STEP_FRACTION_BITS = dqcl_pkg::STEP_FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dqcl_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [dqcl_pkg::DATA_W-1:0]        pwdata,
    output logic      [dqcl_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_func,
    input  wire logic signed [CURRENT_BITS-1:0]     i_value_d,
    input  wire logic signed [CURRENT_BITS-1:0]     i_value_q,
    input  wire logic signed [CURRENT_BITS-1:0]     i_target_d,
    input  wire logic signed [CURRENT_BITS-1:0]     i_target_q,
    input  wire logic                               i_target_was_saturated,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [CURRENT_BITS-1:0]          o_out_d,
    output logic signed [CURRENT_BITS-1:0]          o_out_q,
    output logic                                    o_saturated,
    output logic                                    o_rate_limited
);

    localparam int CB = CURRENT_BITS;
    localparam int S  = STEP_FRACTION_BITS;
    localparam int MW = (CB + 2 > S + 1) ? CB + 2 : S + 1;
    localparam int PW = 2 * MW;
    localparam int FW = 2 * CB + 2 * S + 5;
    localparam int SW = CB + S + 2;
    localparam int KW = $clog2(S);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CHK_X   = 16'h0002,
        S_CHK_Y   = 16'h0004,
        S_CHK_M   = 16'h0008,
        S_CHK_END = 16'h0010,
        S_B_D     = 16'h0020,
        S_B_Q     = 16'h0040,
        S_C_D     = 16'h0080,
        S_C_Q     = 16'h0100,
        S_C_END   = 16'h0200,
        S_IT1     = 16'h0400,
        S_IT2     = 16'h0800,
        S_O_D     = 16'h1000,
        S_O_Q     = 16'h2000,
        S_O_END   = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    // where the registered product goes in the cycle after it is issued
    typedef enum logic [3:0] {
        DST_NONE, DST_F_CLR, DST_F, DST_B_CLR, DST_B,
        DST_C_CLR, DST_C, DST_OD, DST_OQ
    } t_dst;

    t_state r_state, n_state;
    t_dst   r_dst, n_dst;

    logic [CB-2:0] cfg_mag, cfg_d_max, cfg_q_max;
    logic [CB-1:0] cfg_d_min, cfg_q_min;

    dqcl_regs #(.CURRENT_BITS(CB)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mag   (cfg_mag),
        .o_d_min (cfg_d_min),
        .o_d_max (cfg_d_max),
        .o_q_min (cfg_q_min),
        .o_q_max (cfg_q_max)
    );

    dqcl_pkg::t_func  r_func;
    logic signed [CB-1:0] r_vd, r_vq, r_pd, r_pq, r_ref_d, r_ref_q;
    logic signed [CB:0]   r_dd, r_dq;
    logic signed [FW-1:0] r_f, r_bt, r_gt, r_ct, r_inc;
    logic signed [SW-1:0] r_sd, r_sq;
    logic [S-1:0]         r_t;
    logic [KW-1:0]        r_k;
    logic r_rate, r_tsat, r_fsat, r_chk2;
    logic r_ovalid, r_sat_o, r_rate_o;
    logic signed [CB-1:0] r_od, r_oq;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [FW-1:0] pf, trial, gt_next;
    logic signed [SW-1:0] ps;
    logic signed [CB-1:0] cd, cq, shr_d, shr_q;
    logic in_circ, accept, done_go;

    dqcl_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    function automatic logic signed [CB-1:0] clamp_axis(
        input logic signed [CB-1:0] x,
        input logic signed [CB-1:0] lo_raw,
        input logic [CB-2:0]        hi_raw,
        input logic [CB-2:0]        m
    );
        logic signed [CB:0] xe, lo, hi, me, r;
        xe = {x[CB-1], x};
        me = $signed({2'b00, m});
        lo = {lo_raw[CB-1], lo_raw};
        hi = $signed({2'b00, hi_raw});
        if (lo < -me) lo = -me;
        if (hi > me)  hi = me;
        if (xe < lo)      r = lo;
        else if (xe > hi) r = hi;
        else              r = xe;
        return r[CB-1:0];
    endfunction

    // truncate toward zero while dropping the step fraction
    function automatic logic signed [CB-1:0] shrink(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] adj, q;
        adj = s + (s[SW-1] ? {{(SW-S){1'b0}}, {S{1'b1}}} : '0);
        q   = adj >>> S;
        return q[CB-1:0];
    endfunction

    assign cd = clamp_axis(i_value_d, cfg_d_min, cfg_d_max, cfg_mag);
    assign cq = clamp_axis(i_value_q, cfg_q_min, cfg_q_max, cfg_mag);

    assign pf     = {{(FW-PW){prod[PW-1]}}, prod};
    assign ps     = prod[SW-1:0];
    assign in_circ = (r_f <= pf);
    assign trial  = r_f + r_inc;
    assign gt_next = (trial <= 0) ? r_gt + (r_ct <<< 1) : r_gt;
    assign shr_d  = shrink(r_sd);
    assign shr_q  = shrink(r_sq);
    assign accept = i_in_valid & (r_state == S_IDLE);
    assign done_go = (r_state == S_DONE) & (~r_ovalid | ~i_out_stall);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        n_dst = DST_NONE;
        unique case (r_state)
            S_CHK_X: begin
                mul_a = {{(MW-CB){r_pd[CB-1]}}, r_pd};
                mul_b = mul_a;
                n_dst = DST_F_CLR;
            end
            S_CHK_Y: begin
                mul_a = {{(MW-CB){r_pq[CB-1]}}, r_pq};
                mul_b = mul_a;
                n_dst = DST_F;
            end
            S_CHK_M: begin
                mul_a = {{(MW-CB+1){1'b0}}, cfg_mag};
                mul_b = mul_a;
            end
            S_B_D: begin
                mul_a = {{(MW-CB){r_pd[CB-1]}}, r_pd};
                mul_b = {{(MW-CB-1){r_dd[CB]}}, r_dd};
                n_dst = DST_B_CLR;
            end
            S_B_Q: begin
                mul_a = {{(MW-CB){r_pq[CB-1]}}, r_pq};
                mul_b = {{(MW-CB-1){r_dq[CB]}}, r_dq};
                n_dst = DST_B;
            end
            S_C_D: begin
                mul_a = {{(MW-CB-1){r_dd[CB]}}, r_dd};
                mul_b = mul_a;
                n_dst = DST_C_CLR;
            end
            S_C_Q: begin
                mul_a = {{(MW-CB-1){r_dq[CB]}}, r_dq};
                mul_b = mul_a;
                n_dst = DST_C;
            end
            S_O_D: begin
                mul_a = {{(MW-S){1'b0}}, r_t};
                mul_b = {{(MW-CB-1){r_dd[CB]}}, r_dd};
                n_dst = DST_OD;
            end
            S_O_Q: begin
                mul_a = {{(MW-S){1'b0}}, r_t};
                mul_b = {{(MW-CB-1){r_dq[CB]}}, r_dq};
                n_dst = DST_OQ;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (dqcl_pkg::t_func'(i_func) == dqcl_pkg::FUNC_NONE) n_state = S_DONE;
                    else                                                   n_state = S_CHK_X;
                end
            end
            S_CHK_X:   n_state = S_CHK_Y;
            S_CHK_Y:   n_state = S_CHK_M;
            S_CHK_M:   n_state = S_CHK_END;
            S_CHK_END: begin
                if (r_func != dqcl_pkg::FUNC_STEP) n_state = in_circ ? S_DONE : S_B_D;
                else if (!r_chk2)                  n_state = in_circ ? S_DONE : S_CHK_X;
                else                               n_state = in_circ ? S_B_D : S_DONE;
            end
            S_B_D:   n_state = S_B_Q;
            S_B_Q:   n_state = S_C_D;
            S_C_D:   n_state = S_C_Q;
            S_C_Q:   n_state = S_C_END;
            S_C_END: n_state = S_IT1;
            S_IT1:   n_state = S_IT2;
            S_IT2:   n_state = (r_k == '0) ? S_O_D : S_IT1;
            S_O_D:   n_state = S_O_Q;
            S_O_Q:   n_state = S_O_END;
            S_O_END: n_state = S_DONE;
            S_DONE:  if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dst    <= DST_NONE;
            r_ovalid <= 1'b0;
            r_ref_d  <= '0;
            r_ref_q  <= '0;
        end else begin
            r_state <= n_state;
            r_dst   <= n_dst;
            if (done_go) begin
                r_ovalid <= 1'b1;
                if (r_func == dqcl_pkg::FUNC_STEP || r_func == dqcl_pkg::FUNC_RESET) begin
                    r_ref_d <= shr_d;
                    r_ref_q <= shr_q;
                end
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_dst)
            DST_F_CLR: r_f  <= pf;
            DST_F:     r_f  <= r_f + pf;
            DST_B_CLR: r_bt <= pf <<< (2 * S);
            DST_B:     r_bt <= r_bt + (pf <<< (2 * S));
            DST_C_CLR: r_ct <= pf <<< (2 * S - 2);
            DST_C:     r_ct <= r_ct + (pf <<< (2 * S - 2));
            DST_OD:    r_sd <= ({{(SW-CB){r_pd[CB-1]}}, r_pd} <<< S) + ps;
            DST_OQ:    r_sq <= ({{(SW-CB){r_pq[CB-1]}}, r_pq} <<< S) + ps;
            default: ;
        endcase

        if (accept) begin
            r_func <= dqcl_pkg::t_func'(i_func);
            r_vd   <= i_value_d;
            r_vq   <= i_value_q;
            r_tsat <= i_target_was_saturated;
            r_fsat <= 1'b0;
            r_chk2 <= 1'b0;
            r_rate <= (dqcl_pkg::t_func'(i_func) == dqcl_pkg::FUNC_STEP) &&
                      ((i_value_d != i_target_d) || (i_value_q != i_target_q));
            r_sd   <= '0;
            r_sq   <= '0;
            if (dqcl_pkg::t_func'(i_func) == dqcl_pkg::FUNC_STEP) begin
                r_pd <= i_value_d;
                r_pq <= i_value_q;
            end else begin
                r_pd <= cd;
                r_pq <= cq;
            end
        end

        if (r_state == S_CHK_END) begin
            r_gt <= '0;
            r_t  <= '0;
            r_k  <= KW'(S - 1);
            if (r_func != dqcl_pkg::FUNC_STEP) begin
                if (in_circ) begin
                    r_sd <= {{(SW-CB){r_pd[CB-1]}}, r_pd} <<< S;
                    r_sq <= {{(SW-CB){r_pq[CB-1]}}, r_pq} <<< S;
                end else begin
                    // scale the clamped vector from the origin
                    r_dd <= {r_pd[CB-1], r_pd};
                    r_dq <= {r_pq[CB-1], r_pq};
                    r_pd <= '0;
                    r_pq <= '0;
                    r_f  <= (-pf) <<< (2 * S);
                end
            end else if (!r_chk2) begin
                if (in_circ) begin
                    r_sd <= {{(SW-CB){r_pd[CB-1]}}, r_pd} <<< S;
                    r_sq <= {{(SW-CB){r_pq[CB-1]}}, r_pq} <<< S;
                end else begin
                    r_fsat <= 1'b1;
                    r_chk2 <= 1'b1;
                    r_pd   <= r_ref_d;
                    r_pq   <= r_ref_q;
                end
            end else begin
                if (!in_circ) begin
                    r_sd <= {{(SW-CB){r_pd[CB-1]}}, r_pd} <<< S;
                    r_sq <= {{(SW-CB){r_pq[CB-1]}}, r_pq} <<< S;
                end else begin
                    r_dd <= {r_vd[CB-1], r_vd} - {r_pd[CB-1], r_pd};
                    r_dq <= {r_vq[CB-1], r_vq} - {r_pq[CB-1], r_pq};
                    r_f  <= (r_f - pf) <<< (2 * S);
                end
            end
        end

        if (r_state == S_IT1) begin
            r_inc <= r_bt + r_gt + r_ct;
        end

        // try setting bit k of the step; r_bt, r_gt shift down one, r_ct two
        if (r_state == S_IT2) begin
            if (trial <= 0) begin
                r_f <= trial;
                r_t <= r_t | ({{(S-1){1'b0}}, 1'b1} << r_k);
            end
            r_bt <= r_bt >>> 1;
            r_gt <= gt_next >>> 1;
            r_ct <= r_ct >>> 2;
            r_k  <= r_k - 1'b1;
        end

        if (done_go) begin
            r_od <= shr_d;
            r_oq <= shr_q;
            r_rate_o <= r_rate;
            unique case (r_func)
                dqcl_pkg::FUNC_PREPARE,
                dqcl_pkg::FUNC_RESET: r_sat_o <= (shr_d != r_vd) || (shr_q != r_vq);
                dqcl_pkg::FUNC_STEP:  r_sat_o <= r_tsat | r_fsat;
                default:              r_sat_o <= 1'b0;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_out_d        = r_od;
    assign o_out_q        = r_oq;
    assign o_saturated    = r_sat_o;
    assign o_rate_limited = r_rate_o;

endmodule
`default_nettype wire
